// ===== src/cdas_pkg.sv =====
package cdas_pkg;

    // Field widths of the item and result ports
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_FW  = 5;
    localparam int DCNT_W  = 16;
    localparam int CODE_W  = 2;

    // Build constants
    localparam int COUNT_WIDTH = 16;
    localparam int YEAR_MAX    = 2100;

    // Day-count bits actually used, and the signed width of the running day
    localparam int CNT_BITS = (COUNT_WIDTH < DCNT_W) ? COUNT_WIDTH : DCNT_W;
    localparam int DAY_W    = ((CNT_BITS > DAY_FW) ? CNT_BITS : DAY_FW) + 2;

    // Year split into century and year-of-century: y = q * 100 + r.
    // q = (y * YEAR_RECIP) >> YEAR_RECIP_SH is exact for every 12-bit year.
    localparam int YEARS_PER_CENT = 100;
    localparam int YEAR_RECIP     = 5243;
    localparam int YEAR_RECIP_W   = 13;
    localparam int YEAR_RECIP_SH  = 19;
    localparam int CENT_W         = 6;
    localparam int YOC_W          = 7;
    localparam int PROD_W         = YEAR_W + YEAR_RECIP_W;

    localparam int MONTHS   = 12;
    localparam int LEAP_FEB = 29;

    localparam logic [YEAR_W-1:0]  RST_YEAR  = YEAR_W'(1900);
    localparam logic [MONTH_W-1:0] RST_MONTH = MONTH_W'(1);
    localparam logic [DAY_FW-1:0]  RST_DAY   = DAY_FW'(1);

    typedef enum logic [CODE_W-1:0] {
        ACT_LOAD = 2'd0,
        ACT_ADD  = 2'd1,
        ACT_SUB  = 2'd2,
        ACT_CMP  = 2'd3
    } t_action;

    typedef enum logic [CODE_W-1:0] {
        REL_LESS    = 2'd0,
        REL_EQUAL   = 2'd1,
        REL_GREATER = 2'd2
    } t_relation;

    typedef enum logic [CODE_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic capture;
        logic split_q;
        logic split_r;
        logic step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_stat;

    localparam logic [DAY_FW-1:0] MONTH_LEN [MONTHS] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    function automatic logic is_leap(input logic [CENT_W-1:0] q,
                                     input logic [YOC_W-1:0] r);
        logic leap;
        leap = ((r[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
        return leap;
    endfunction

    function automatic logic [DAY_FW-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_FW-1:0] len;
        if ((m < MONTH_W'(1)) || (m > MONTH_W'(MONTHS))) begin
            len = DAY_FW'(31);
        end else if ((m == MONTH_W'(2)) && leap) begin
            len = DAY_FW'(LEAP_FEB);
        end else begin
            len = MONTH_LEN[m - MONTH_W'(1)];
        end
        return len;
    endfunction

endpackage

// ===== src/cdas_ctrl.sv =====
module cdas_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    input  cdas_pkg::t_dp_stat i_stat,
    output logic               o_stall,
    output logic               o_valid,
    output cdas_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT_Q,
        S_SPLIT_R,
        S_RUN,
        S_PUBLISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = accept;
        o_cmd.split_q = (r_state == S_SPLIT_Q);
        o_cmd.split_r = (r_state == S_SPLIT_R);
        o_cmd.step    = (r_state == S_RUN);
        o_cmd.publish = (r_state == S_PUBLISH) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SPLIT_Q;
                    end
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_SPLIT_Q: begin
                    r_state <= S_SPLIT_R;
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_SPLIT_R: begin
                    r_state <= S_RUN;
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_RUN: begin
                    if (i_stat.done) begin
                        r_state <= S_PUBLISH;
                    end
                    if (!i_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_PUBLISH: begin
                    // Hold the result until the output register frees up
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/cdas_datapath.sv =====
module cdas_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cdas_pkg::t_dp_cmd                    i_cmd,
    input  logic [cdas_pkg::CODE_W-1:0]          i_action,
    input  logic [cdas_pkg::YEAR_W-1:0]          i_in_year,
    input  logic [cdas_pkg::MONTH_W-1:0]         i_in_month,
    input  logic [cdas_pkg::DAY_FW-1:0]          i_in_day,
    input  logic [cdas_pkg::DCNT_W-1:0]          i_day_count,
    output cdas_pkg::t_dp_stat                   o_stat,
    output logic [cdas_pkg::YEAR_W-1:0]          o_out_year,
    output logic [cdas_pkg::MONTH_W-1:0]         o_out_month,
    output logic [cdas_pkg::DAY_FW-1:0]          o_out_day,
    output logic [cdas_pkg::CODE_W-1:0]          o_relation,
    output logic [cdas_pkg::CODE_W-1:0]          o_status
);

    localparam int YW = cdas_pkg::YEAR_W;
    localparam int MW = cdas_pkg::MONTH_W;
    localparam int FW = cdas_pkg::DAY_FW;
    localparam int DW = cdas_pkg::DAY_W;
    localparam int QW = cdas_pkg::CENT_W;
    localparam int RW = cdas_pkg::YOC_W;

    // Stored date
    logic [YW-1:0] r_cur_year;
    logic [MW-1:0] r_cur_month;
    logic [FW-1:0] r_cur_day;

    // Captured item and working date
    cdas_pkg::t_action   r_act;
    logic [YW-1:0]       r_gy;
    logic [MW-1:0]       r_gm;
    logic [FW-1:0]       r_gd;
    logic [YW-1:0]       r_wy;
    logic [MW-1:0]       r_wm;
    logic signed [DW-1:0] r_wd;
    logic [QW-1:0]       r_q;
    logic [RW-1:0]       r_r;

    // Result registers
    cdas_pkg::t_relation r_rel;
    cdas_pkg::t_status   r_st;
    logic [YW-1:0]       r_o_year;
    logic [MW-1:0]       r_o_month;
    logic [FW-1:0]       r_o_day;
    logic [1:0]          r_o_rel;
    logic [1:0]          r_o_st;

    // Capture terms
    cdas_pkg::t_action    in_act;
    logic signed [DW-1:0] cnt_ext;
    logic signed [DW-1:0] day_ext;

    // Year split
    logic [cdas_pkg::PROD_W-1:0] recip_prod;
    logic [YW-1:0]               cent_years;

    // Step terms
    logic                 leap_cur;
    logic [FW-1:0]        ml_cur;
    logic signed [DW-1:0] ml_cur_ext;
    logic                 add_more;
    logic [YW:0]          year_inc;
    logic                 add_wrap;
    logic                 add_bad;
    logic [QW-1:0]        q_inc;
    logic [RW-1:0]        r_inc;
    logic                 sub_more;
    logic                 sub_wrap;
    logic                 sub_bad;
    logic [QW-1:0]        q_dec;
    logic [RW-1:0]        r_dec;
    logic [QW-1:0]        q_prev;
    logic [RW-1:0]        r_prev;
    logic [MW-1:0]        m_prev;
    logic [FW-1:0]        ml_prev;
    logic                 load_ok;
    cdas_pkg::t_relation  cmp_rel;
    logic                 done;

    assign in_act  = cdas_pkg::t_action'(i_action);
    assign cnt_ext = $signed(DW'(i_day_count[cdas_pkg::CNT_BITS-1:0]));
    assign day_ext = $signed(DW'(r_cur_day));

    assign recip_prod = cdas_pkg::PROD_W'(r_wy) *
                        cdas_pkg::PROD_W'(cdas_pkg::YEAR_RECIP);
    assign cent_years = YW'(r_q) * YW'(cdas_pkg::YEARS_PER_CENT);

    always_comb begin
        leap_cur   = cdas_pkg::is_leap(r_q, r_r);
        ml_cur     = cdas_pkg::month_len(r_wm, leap_cur);
        ml_cur_ext = $signed(DW'(ml_cur));

        // Forward: one month per step
        add_more = (r_wd > ml_cur_ext);
        add_wrap = (r_wm >= MW'(cdas_pkg::MONTHS));
        year_inc = {1'b0, r_wy} + (YW + 1)'(1);
        add_bad  = add_more && add_wrap && (year_inc > (YW + 1)'(cdas_pkg::YEAR_MAX));
        if (r_r == RW'(cdas_pkg::YEARS_PER_CENT - 1)) begin
            r_inc = '0;
            q_inc = r_q + QW'(1);
        end else begin
            r_inc = r_r + RW'(1);
            q_inc = r_q;
        end

        // Backward: step to the previous month, then borrow its length
        sub_more = (r_wd <= $signed(DW'(0)));
        sub_wrap = (r_wm <= MW'(1));
        sub_bad  = sub_more && sub_wrap && (r_wy == '0);
        if (r_r == '0) begin
            r_dec = RW'(cdas_pkg::YEARS_PER_CENT - 1);
            q_dec = r_q - QW'(1);
        end else begin
            r_dec = r_r - RW'(1);
            q_dec = r_q;
        end
        if (sub_wrap) begin
            q_prev = q_dec;
            r_prev = r_dec;
            m_prev = MW'(cdas_pkg::MONTHS);
        end else begin
            q_prev = r_q;
            r_prev = r_r;
            m_prev = r_wm - MW'(1);
        end
        ml_prev = cdas_pkg::month_len(m_prev, cdas_pkg::is_leap(q_prev, r_prev));

        // Load check; working year equals the given year here
        load_ok = (r_gy <= YW'(cdas_pkg::YEAR_MAX)) &&
                  (r_gm >= MW'(1)) && (r_gm <= MW'(cdas_pkg::MONTHS)) &&
                  (r_gd >= FW'(1)) && (r_gd <= ml_cur);

        priority if (r_cur_year != r_gy) begin
            cmp_rel = (r_cur_year > r_gy) ? cdas_pkg::REL_GREATER : cdas_pkg::REL_LESS;
        end else if (r_cur_month != r_gm) begin
            cmp_rel = (r_cur_month > r_gm) ? cdas_pkg::REL_GREATER : cdas_pkg::REL_LESS;
        end else if (r_cur_day != r_gd) begin
            cmp_rel = (r_cur_day > r_gd) ? cdas_pkg::REL_GREATER : cdas_pkg::REL_LESS;
        end else begin
            cmp_rel = cdas_pkg::REL_EQUAL;
        end

        unique case (r_act)
            cdas_pkg::ACT_ADD: done = !add_more || add_bad;
            cdas_pkg::ACT_SUB: done = !sub_more || sub_bad;
            default:           done = 1'b1;
        endcase
    end

    assign o_stat.done = done;

    // Stored date
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_year  <= cdas_pkg::RST_YEAR;
            r_cur_month <= cdas_pkg::RST_MONTH;
            r_cur_day   <= cdas_pkg::RST_DAY;
        end else if (i_cmd.step && done) begin
            unique case (r_act)
                cdas_pkg::ACT_LOAD: begin
                    if (load_ok) begin
                        r_cur_year  <= r_gy;
                        r_cur_month <= r_gm;
                        r_cur_day   <= r_gd;
                    end
                end
                cdas_pkg::ACT_ADD: begin
                    if (!add_bad) begin
                        r_cur_year  <= r_wy;
                        r_cur_month <= r_wm;
                        r_cur_day   <= FW'(r_wd);
                    end
                end
                cdas_pkg::ACT_SUB: begin
                    if (!sub_bad) begin
                        r_cur_year  <= r_wy;
                        r_cur_month <= r_wm;
                        r_cur_day   <= FW'(r_wd);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= in_act;
            r_gy  <= i_in_year;
            r_gm  <= i_in_month;
            r_gd  <= i_in_day;
            if ((in_act == cdas_pkg::ACT_LOAD) || (in_act == cdas_pkg::ACT_CMP)) begin
                r_wy <= i_in_year;
                r_wm <= i_in_month;
            end else begin
                r_wy <= r_cur_year;
                r_wm <= r_cur_month;
            end
            if (in_act == cdas_pkg::ACT_SUB) begin
                r_wd <= day_ext - cnt_ext;
            end else begin
                r_wd <= day_ext + cnt_ext;
            end
        end
        if (i_cmd.split_q) begin
            r_q <= recip_prod[cdas_pkg::YEAR_RECIP_SH +: QW];
        end
        if (i_cmd.split_r) begin
            r_r <= RW'(r_wy - cent_years);
        end
        if (i_cmd.step) begin
            if (done) begin
                unique case (r_act)
                    cdas_pkg::ACT_LOAD: begin
                        r_rel <= cdas_pkg::REL_LESS;
                        if (load_ok) begin
                            r_st <= cdas_pkg::ST_OK;
                        end else begin
                            r_st <= cdas_pkg::ST_INVALID;
                        end
                    end
                    cdas_pkg::ACT_ADD: begin
                        r_rel <= cdas_pkg::REL_LESS;
                        if (add_bad) begin
                            r_st <= cdas_pkg::ST_RANGE;
                        end else begin
                            r_st <= cdas_pkg::ST_OK;
                        end
                    end
                    cdas_pkg::ACT_SUB: begin
                        r_rel <= cdas_pkg::REL_LESS;
                        if (sub_bad) begin
                            r_st <= cdas_pkg::ST_RANGE;
                        end else begin
                            r_st <= cdas_pkg::ST_OK;
                        end
                    end
                    cdas_pkg::ACT_CMP: begin
                        r_rel <= cmp_rel;
                        r_st  <= cdas_pkg::ST_OK;
                    end
                endcase
            end else if (r_act == cdas_pkg::ACT_ADD) begin
                r_wd <= r_wd - ml_cur_ext;
                if (add_wrap) begin
                    r_wy <= year_inc[YW-1:0];
                    r_wm <= MW'(1);
                    r_q  <= q_inc;
                    r_r  <= r_inc;
                end else begin
                    r_wm <= r_wm + MW'(1);
                end
            end else begin
                r_wd <= r_wd + $signed(DW'(ml_prev));
                r_wm <= m_prev;
                r_q  <= q_prev;
                r_r  <= r_prev;
                if (sub_wrap) begin
                    r_wy <= r_wy - YW'(1);
                end
            end
        end
        if (i_cmd.publish) begin
            r_o_year  <= r_cur_year;
            r_o_month <= r_cur_month;
            r_o_day   <= r_cur_day;
            r_o_rel   <= r_rel;
            r_o_st    <= r_st;
        end
    end

    assign o_out_year  = r_o_year;
    assign o_out_month = r_o_month;
    assign o_out_day   = r_o_day;
    assign o_relation  = r_o_rel;
    assign o_status    = r_o_st;

endmodule

// ===== src/calendar_date_add_subtract_unit.sv =====
// Gregorian date unit: holds one date (reset 1900-01-01) and takes one item at
// a time on a valid/stall channel. An item loads a date (checked; status 1 and
// the old date kept if invalid), adds or subtracts a day count, or compares the
// stored date with the given one (relation 0 less, 1 equal, 2 greater). Each
// item returns one result: the stored date after the item, the relation and a
// status; status 2 means the year would leave 0..YEAR_MAX and the old date is
// kept. An add or subtract steps the working date one month per cycle until
// the day lies within its month, so it takes longer the more month boundaries
// it crosses. The input stalls from acceptance until the result is placed in
// the output register.
module calendar_date_add_subtract_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Item channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [cdas_pkg::CODE_W-1:0]         i_action,
    input  logic [cdas_pkg::YEAR_W-1:0]         i_in_year,
    input  logic [cdas_pkg::MONTH_W-1:0]        i_in_month,
    input  logic [cdas_pkg::DAY_FW-1:0]         i_in_day,
    input  logic [cdas_pkg::DCNT_W-1:0]         i_day_count,
    // Result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [cdas_pkg::YEAR_W-1:0]         o_out_year,
    output logic [cdas_pkg::MONTH_W-1:0]        o_out_month,
    output logic [cdas_pkg::DAY_FW-1:0]         o_out_day,
    output logic [cdas_pkg::CODE_W-1:0]         o_relation,
    output logic [cdas_pkg::CODE_W-1:0]         o_status
);

    // Command and status between the sequencer and the date datapath
    cdas_pkg::t_dp_cmd  dp_cmd;
    cdas_pkg::t_dp_stat dp_stat;

    // Sequencer: capture, split the year into century and year-of-century,
    // step month by month until done, then publish into the output register
    cdas_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd)
    );

    // Datapath: stored date, working date, leap/month-length logic, result regs
    cdas_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_action    (i_action),
        .i_in_year   (i_in_year),
        .i_in_month  (i_in_month),
        .i_in_day    (i_in_day),
        .i_day_count (i_day_count),
        .o_stat      (dp_stat),
        .o_out_year  (o_out_year),
        .o_out_month (o_out_month),
        .o_out_day   (o_out_day),
        .o_relation  (o_relation),
        .o_status    (o_status)
    );

endmodule

// ===== test/calendar_date_add_subtract_unit_test.sv =====
`timescale 1ns / 100ps

module calendar_date_add_subtract_unit_test;

    // Safety net on run length. The slowest correct run is roughly 300 items,
    // each stepping ~2200 months and waiting out receiver stalls, plus the long
    // hold-off; CYCLE_LIMIT is set well above that.
    localparam int CYCLE_LIMIT   = 2_500_000;
    localparam int HOLD_CYCLES   = 6000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;

    localparam int NORMAL_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    // One expected result: the stored date after the item plus relation and status
    typedef struct packed {
        logic [cdas_pkg::YEAR_W-1:0]  year;
        logic [cdas_pkg::MONTH_W-1:0] month;
        logic [cdas_pkg::DAY_FW-1:0]  day;
        cdas_pkg::t_relation          rel;
        cdas_pkg::t_status            st;
    } t_date_result;

    // Clock, reset and the item channel
    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_stall;
    logic [cdas_pkg::CODE_W-1:0]   i_action    = '0;
    logic [cdas_pkg::YEAR_W-1:0]   i_in_year   = '0;
    logic [cdas_pkg::MONTH_W-1:0]  i_in_month  = '0;
    logic [cdas_pkg::DAY_FW-1:0]   i_in_day    = '0;
    logic [cdas_pkg::DCNT_W-1:0]   i_day_count = '0;

    // Result channel
    logic                          o_valid;
    logic                          i_stall     = 1'b0;
    logic [cdas_pkg::YEAR_W-1:0]   o_out_year;
    logic [cdas_pkg::MONTH_W-1:0]  o_out_month;
    logic [cdas_pkg::DAY_FW-1:0]   o_out_day;
    logic [cdas_pkg::CODE_W-1:0]   o_relation;
    logic [cdas_pkg::CODE_W-1:0]   o_status;

    // Idle rates in percent, changed between phases by the test tasks
    int sender_gap_pct   = 0;
    int receiver_gap_pct = 0;
    logic hold_results   = 1'b0;

    int mismatch_count = 0;
    int cycle_count    = 0;

    // Shadow copy of the stored date, kept in step with accepted items
    int shadow_year  = 1900;
    int shadow_month = 1;
    int shadow_day   = 1;

    t_date_result pending_dates [$];

    calendar_date_add_subtract_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_action    (i_action),
        .i_in_year   (i_in_year),
        .i_in_month  (i_in_month),
        .i_in_day    (i_in_day),
        .i_day_count (i_day_count),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_year  (o_out_year),
        .o_out_month (o_out_month),
        .o_out_day   (o_out_day),
        .o_relation  (o_relation),
        .o_status    (o_status)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Days in month m of year y under the Gregorian rule; an out-of-range
    // month counts as 31 days, as the block does.
    function automatic int days_in(input int y, input int m);
        bit leap_year;
        leap_year = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        if (m < 1 || m > 12) return 31;
        if (m == 2 && leap_year) return 29;
        return NORMAL_DAYS[m - 1];
    endfunction

    // Apply one item to the shadow date and return the result it must produce.
    // A rejected load or a step that leaves the year range keeps the old date.
    function automatic t_date_result apply_date_action(
            input cdas_pkg::t_action act,
            input logic [cdas_pkg::YEAR_W-1:0] gy,
            input logic [cdas_pkg::MONTH_W-1:0] gm,
            input logic [cdas_pkg::DAY_FW-1:0] gd,
            input logic [cdas_pkg::DCNT_W-1:0] cnt);
        t_date_result res;
        int y;
        int m;
        int d;
        int n;
        bit out_of_range;
        n = int'(cnt) & ((1 << cdas_pkg::COUNT_WIDTH) - 1);
        res.rel = cdas_pkg::REL_LESS;
        res.st = cdas_pkg::ST_OK;
        out_of_range = 1'b0;
        case (act)
            cdas_pkg::ACT_LOAD: begin
                if (gy > cdas_pkg::YEAR_MAX || gm < 1 || gm > 12 || gd < 1 ||
                    int'(gd) > days_in(gy, gm)) begin
                    res.st = cdas_pkg::ST_INVALID;
                end else begin
                    shadow_year = gy;
                    shadow_month = gm;
                    shadow_day = gd;
                end
            end
            cdas_pkg::ACT_ADD: begin
                y = shadow_year;
                m = shadow_month;
                d = shadow_day + n;
                // Roll forward one month at a time; stop once the year passes the top
                while (d > days_in(y, m)) begin
                    d -= days_in(y, m);
                    if (m >= 12) begin
                        y++;
                        m = 1;
                        if (y > cdas_pkg::YEAR_MAX) begin
                            out_of_range = 1'b1;
                            break;
                        end
                    end else begin
                        m++;
                    end
                end
                if (out_of_range) begin
                    res.st = cdas_pkg::ST_RANGE;
                end else begin
                    shadow_year = y;
                    shadow_month = m;
                    shadow_day = d;
                end
            end
            cdas_pkg::ACT_SUB: begin
                y = shadow_year;
                m = shadow_month;
                d = shadow_day - n;
                // Borrow whole months while the day is zero or negative
                while (d <= 0) begin
                    if (m <= 1) begin
                        if (y == 0) begin
                            out_of_range = 1'b1;
                            break;
                        end
                        y--;
                        m = 12;
                    end else begin
                        m--;
                    end
                    d += days_in(y, m);
                end
                if (out_of_range) begin
                    res.st = cdas_pkg::ST_RANGE;
                end else begin
                    shadow_year = y;
                    shadow_month = m;
                    shadow_day = d;
                end
            end
            default: begin
                // Compare raw fields, most significant first; nothing is validated
                if (shadow_year != gy) begin
                    if (shadow_year > gy) res.rel = cdas_pkg::REL_GREATER;
                end else if (shadow_month != gm) begin
                    if (shadow_month > gm) res.rel = cdas_pkg::REL_GREATER;
                end else if (shadow_day != gd) begin
                    if (shadow_day > gd) res.rel = cdas_pkg::REL_GREATER;
                end else begin
                    res.rel = cdas_pkg::REL_EQUAL;
                end
            end
        endcase
        res.year = cdas_pkg::YEAR_W'(shadow_year);
        res.month = cdas_pkg::MONTH_W'(shadow_month);
        res.day = cdas_pkg::DAY_FW'(shadow_day);
        return res;
    endfunction

    // Offer one item and hold it until accepted, then queue its expected result.
    // Call at a falling edge; returns at a falling edge with valid still high,
    // so a following item does not lower and raise valid in one step.
    task automatic send_item(input cdas_pkg::t_action act,
                             input logic [cdas_pkg::YEAR_W-1:0] gy,
                             input logic [cdas_pkg::MONTH_W-1:0] gm,
                             input logic [cdas_pkg::DAY_FW-1:0] gd,
                             input logic [cdas_pkg::DCNT_W-1:0] cnt);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= act;
        i_in_year   <= gy;
        i_in_month  <= gm;
        i_in_day    <= gd;
        i_day_count <= cnt;
        do @(posedge i_clk); while (o_stall);
        pending_dates.push_back(apply_date_action(act, gy, gm, gd, cnt));
        @(negedge i_clk);
    endtask

    // Mostly short steps, now and then a long one that crosses many years
    function automatic logic [cdas_pkg::DCNT_W-1:0] pick_day_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return cdas_pkg::DCNT_W'($urandom_range(0, 40));
        if (pick < 85) return cdas_pkg::DCNT_W'($urandom_range(0, 800));
        if (pick < 95) return cdas_pkg::DCNT_W'($urandom_range(0, 20000));
        return cdas_pkg::DCNT_W'($urandom_range(0, 65535));
    endfunction

    // Random items: mostly valid loads, steps of varied size and compares
    // aimed at or next to the stored date; the rest raw field noise.
    task automatic send_random_dates(input int n);
        cdas_pkg::t_action             act;
        logic [cdas_pkg::YEAR_W-1:0]   y;
        logic [cdas_pkg::MONTH_W-1:0]  m;
        logic [cdas_pkg::DAY_FW-1:0]   d;
        logic [cdas_pkg::DCNT_W-1:0]   c;
        int pick;
        for (int k = 0; k < n; k++) begin
            y = cdas_pkg::YEAR_W'($urandom_range(0, cdas_pkg::YEAR_MAX));
            m = cdas_pkg::MONTH_W'($urandom_range(0, 15));
            d = cdas_pkg::DAY_FW'($urandom_range(0, 31));
            c = cdas_pkg::DCNT_W'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                act = cdas_pkg::ACT_LOAD;
                if ($urandom_range(0, 99) < 75) begin
                    m = cdas_pkg::MONTH_W'($urandom_range(1, 12));
                    d = cdas_pkg::DAY_FW'($urandom_range(1, days_in(y, m)));
                end
            end else if (pick < 55) begin
                act = cdas_pkg::ACT_ADD;
                c = pick_day_count();
            end else if (pick < 80) begin
                act = cdas_pkg::ACT_SUB;
                c = pick_day_count();
            end else begin
                act = cdas_pkg::ACT_CMP;
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    y = cdas_pkg::YEAR_W'(shadow_year);
                    m = cdas_pkg::MONTH_W'(shadow_month);
                    d = cdas_pkg::DAY_FW'(shadow_day);
                end
                // Nudge one field by one to land just beside the stored date
                if (pick >= 4 && pick < 7) begin
                    case ($urandom_range(0, 2))
                        0: y = $urandom_range(0, 1) ? y + 1'b1 : y - 1'b1;
                        1: m = $urandom_range(0, 1) ? m + 1'b1 : m - 1'b1;
                        default: d = $urandom_range(0, 1) ? d + 1'b1 : d - 1'b1;
                    endcase
                end
            end
            send_item(act, y, m, d, c);
        end
    endtask

    // Hold reset asserted, then release it at a falling edge
    task automatic reset_dut();
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Extremes of every field, every action and each corner of the calendar
    task automatic test_directed();
        sender_gap_pct = 17;
        receiver_gap_pct = 86;
        send_item(cdas_pkg::ACT_CMP,  12'd1900, 4'd1,  5'd1,  16'd0);  // reset date equals itself
        send_item(cdas_pkg::ACT_LOAD, 12'd0,    4'd1,  5'd1,  16'hFFFF);  // lowest year
        send_item(cdas_pkg::ACT_SUB,  12'd0,    4'd0,  5'd0,  16'd0);     // zero-day step
        send_item(cdas_pkg::ACT_SUB,  12'd0,    4'd0,  5'd0,  16'd1);     // underflow below 0
        send_item(cdas_pkg::ACT_LOAD, 12'd2100, 4'd12, 5'd31, 16'd0);     // top of the range
        send_item(cdas_pkg::ACT_ADD,  12'd0,    4'd0,  5'd0,  16'd1);     // overflow past top
        send_item(cdas_pkg::ACT_ADD,  12'd0,    4'd0,  5'd0,  16'd0);
        send_item(cdas_pkg::ACT_CMP,  12'd2100, 4'd12, 5'd31, 16'd0);
        send_item(cdas_pkg::ACT_LOAD, 12'd2100, 4'd2,  5'd29, 16'd0);     // century, not leap
        send_item(cdas_pkg::ACT_LOAD, 12'd1900, 4'd2,  5'd29, 16'd0);
        send_item(cdas_pkg::ACT_LOAD, 12'd2024, 4'd4,  5'd31, 16'd0);     // day past month end
        send_item(cdas_pkg::ACT_LOAD, 12'd2024, 4'd0,  5'd10, 16'd0);     // month zero
        send_item(cdas_pkg::ACT_LOAD, 12'd2024, 4'd13, 5'd1,  16'd0);
        send_item(cdas_pkg::ACT_LOAD, 12'd2024, 4'd15, 5'd31, 16'd0);
        send_item(cdas_pkg::ACT_LOAD, 12'd2024, 4'd5,  5'd0,  16'd0);     // day zero
        send_item(cdas_pkg::ACT_LOAD, 12'd2101, 4'd1,  5'd1,  16'd0);     // year past the top
        send_item(cdas_pkg::ACT_LOAD, 12'hFFF,  4'd15, 5'd31, 16'd0);     // every bit set
        send_item(cdas_pkg::ACT_LOAD, 12'd2000, 4'd2,  5'd29, 16'd0);     // 400-year leap
        send_item(cdas_pkg::ACT_ADD,  12'd0,    4'd0,  5'd0,  16'd365);
        send_item(cdas_pkg::ACT_LOAD, 12'd2024, 4'd3,  5'd1,  16'd0);
        send_item(cdas_pkg::ACT_SUB,  12'd0,    4'd0,  5'd0,  16'd1);     // into leap February
        send_item(cdas_pkg::ACT_SUB,  12'd0,    4'd0,  5'd0,  16'hFFFF);  // largest count back
        send_item(cdas_pkg::ACT_ADD,  12'd0,    4'd0,  5'd0,  16'hFFFF);  // and forward again
        send_item(cdas_pkg::ACT_CMP,  12'd2024, 4'd15, 5'd31, 16'd0);     // invalid operand
        send_item(cdas_pkg::ACT_CMP,  12'd0,    4'd0,  5'd0,  16'd0);     // greater
        send_item(cdas_pkg::ACT_LOAD, 12'd1999, 4'd12, 5'd31, 16'd0);
        send_item(cdas_pkg::ACT_ADD,  12'd0,    4'd0,  5'd0,  16'd1);     // year rollover
    endtask

    // Slow receiver, busy sender
    task automatic test_slow_receiver();
        sender_gap_pct = 17;
        receiver_gap_pct = 86;
        send_random_dates(80);
    endtask

    // Idle sender, eager receiver
    task automatic test_slow_sender();
        sender_gap_pct = 86;
        receiver_gap_pct = 17;
        send_random_dates(80);
    endtask

    // Freeze the receiver for a long stretch while items keep coming, so the
    // block fills up and stalls its input
    task automatic test_backpressure();
        sender_gap_pct = 0;
        receiver_gap_pct = 0;
        fork
            begin
                @(posedge i_clk);
                hold_results <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results <= 1'b0;
            end
        join_none
        send_random_dates(12);
    endtask

    // Full rate on both sides
    task automatic test_full_rate();
        sender_gap_pct = 0;
        receiver_gap_pct = 0;
        send_random_dates(80);
    endtask

    // Receiver: stall at random, or hard while a hold-off is running
    always @(negedge i_clk) begin
        i_stall <= hold_results || ($urandom_range(0, 99) < receiver_gap_pct);
    end

    task automatic log_mismatch(input string field, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch on %s at cycle %0d: expected %0d, got %0d",
                     field, cycle_count, want, got);
        end
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_date_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dates.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("Unexpected result at cycle %0d: %0d-%0d-%0d rel %0d status %0d",
                             cycle_count, o_out_year, o_out_month, o_out_day,
                             o_relation, o_status);
                end
            end else begin
                want = pending_dates.pop_front();
                if (o_out_year !== want.year)   log_mismatch("year", want.year, o_out_year);
                if (o_out_month !== want.month) log_mismatch("month", want.month, o_out_month);
                if (o_out_day !== want.day)     log_mismatch("day", want.day, o_out_day);
                if (o_relation !== want.rel)    log_mismatch("relation", want.rel, o_relation);
                if (o_status !== want.st)       log_mismatch("status", want.st, o_status);
            end
        end
    end

    // Watchdog: end the run if the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_dates.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        reset_dut();
        test_directed();
        test_slow_receiver();
        test_slow_sender();
        test_backpressure();
        test_full_rate();
        i_valid <= 1'b0;
        // Drain: wait for every outstanding result, then idle for DRAIN_CYCLES
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/cdas_pkg.sv
src/cdas_ctrl.sv
src/cdas_datapath.sv
src/calendar_date_add_subtract_unit.sv
test/calendar_date_add_subtract_unit_test.sv
